// File: rtl/bed_pkg.sv
package bed_pkg;

   // Fixed field widths
   localparam int CFG_DIM_W  = 9;
   localparam int CFG_DATA_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 8;
   localparam int SLOTS      = 4;

   localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
   localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd2;

   // Reset values of the registers
   localparam logic [CFG_DIM_W-1:0] RESET_WIDTH  = 9'd200;
   localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT = 9'd200;
   localparam logic                 MODE_ERODE   = 1'b0;
   localparam logic                 MODE_DILATE  = 1'b1;

   // Result slots of one request, in emission order
   localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;  // (r-1, c-1)
   localparam logic [1:0] SLOT_UP       = 2'd1;  // (r-1, c)
   localparam logic [1:0] SLOT_LEFT     = 2'd2;  // (r, c-1)
   localparam logic [1:0] SLOT_CORNER   = 2'd3;  // (r, c), closes the frame

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_DIM_W-1:0] image_height;
      logic                 mode;
   } cfg_type;

   // Up to four results caused by one request
   typedef struct packed {
      logic [SLOTS-1:0]   mask;
      logic [SLOTS-1:0]   bits;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } bundle_type;

   localparam int BUNDLE_W = $bits(bundle_type);

   // AND for erosion, OR for dilation
   function automatic logic combine4(input logic mode, input logic a, input logic b,
                                     input logic c, input logic d);
      logic res;
      if (mode == MODE_DILATE) begin
         res = a | b | c | d;
      end else begin
         res = a & b & c & d;
      end
      return res;
   endfunction

   // Lowest set slot of a mask
   function automatic logic [1:0] low_slot(input logic [SLOTS-1:0] mask);
      logic [1:0] idx;
      priority if (mask[0]) begin
         idx = SLOT_UP_LEFT;
      end else if (mask[1]) begin
         idx = SLOT_UP;
      end else if (mask[2]) begin
         idx = SLOT_LEFT;
      end else begin
         idx = SLOT_CORNER;
      end
      return idx;
   endfunction

endpackage

// File: rtl/bed_ram.sv
module bed_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bed_front.sv
module bed_front
   import bed_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             push,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             queue_full,
   output logic             bundle_valid,
   output bundle_type       bundle
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DW_C  = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
   localparam int DW_R  = (ROW_W + 1 > CFG_DIM_W) ? ROW_W + 1 : CFG_DIM_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             left_ff, left_in;
   logic             upleft_ff, upleft_in;
   logic             byp_ff, byp_in;
   logic             byp_bit_ff;

   logic             accept;
   logic             cur;
   logic             above;
   logic             ram_rdata;
   logic [DW_C-1:0]  width_ext, width_cl;
   logic [DW_R-1:0]  height_ext, height_cl;
   logic             end_col, end_row;
   logic             r_ge1, c_ge1;
   logic [SLOTS-1:0] mask;
   logic [SLOTS-1:0] bits;

   assign accept = push && !queue_full;
   assign cur    = (req_pixel == FG_VALUE);

   // Clamp the frame size to the supported range
   assign width_ext  = DW_C'(cfg.image_width);
   assign height_ext = DW_R'(cfg.image_height);

   always_comb begin
      priority if (width_ext == '0) begin
         width_cl = DW_C'(1);
      end else if (width_ext > DW_C'(MAX_WIDTH)) begin
         width_cl = DW_C'(MAX_WIDTH);
      end else begin
         width_cl = width_ext;
      end
      priority if (height_ext == '0) begin
         height_cl = DW_R'(1);
      end else if (height_ext > DW_R'(MAX_HEIGHT)) begin
         height_cl = DW_R'(MAX_HEIGHT);
      end else begin
         height_cl = height_ext;
      end
   end

   assign end_col = DW_C'(col_ff) >= (width_cl - DW_C'(1));
   assign end_row = DW_R'(row_ff) >= (height_cl - DW_R'(1));
   assign r_ge1   = (row_ff != '0);
   assign c_ge1   = (col_ff != '0);

   // Previous row; the entry for the next column is read ahead on the registered read port
   bed_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (cur),
      .raddr (col_in),
      .rdata (ram_rdata)
   );

   // Forward a bit written to the column that is read next (single-column frames)
   assign above = byp_ff ? byp_bit_ff : ram_rdata;

   // Classify the request into its result slots
   always_comb begin
      mask[SLOT_UP_LEFT] = r_ge1 && c_ge1;
      mask[SLOT_UP]      = r_ge1 && end_col;
      mask[SLOT_LEFT]    = end_row && c_ge1;
      mask[SLOT_CORNER]  = end_row && end_col;
      bits[SLOT_UP_LEFT] = combine4(cfg.mode, upleft_ff, above, left_ff, cur);
      bits[SLOT_UP]      = combine4(cfg.mode, above, 1'b0, cur, 1'b0);
      bits[SLOT_LEFT]    = combine4(cfg.mode, left_ff, cur, 1'b0, 1'b0);
      bits[SLOT_CORNER]  = combine4(cfg.mode, cur, 1'b0, 1'b0, 1'b0);
   end

   assign bundle_valid = accept && (mask != '0);
   assign bundle.mask  = mask;
   assign bundle.bits  = bits;
   assign bundle.row   = COORD_W'(row_ff);
   assign bundle.col   = COORD_W'(col_ff);

   // Advance the raster position
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (accept) begin
         if (end_col) begin
            col_in    = '0;
            row_in    = end_row ? '0 : row_ff + ROW_W'(1);
            left_in   = 1'b0;
            upleft_in = 1'b0;
         end else begin
            col_in    = col_ff + COL_W'(1);
            left_in   = cur;
            upleft_in = above;
         end
      end
      byp_in = accept && (col_in == col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= 1'b0;
         upleft_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
         byp_ff    <= byp_in;
      end
   end

   // Capture the current pixel bit; the bypass uses it only after an accepted write
   always_ff @(posedge clock) begin
      byp_bit_ff <= cur;
   end

endmodule

// File: rtl/bed_fifo.sv
module bed_fifo
   import bed_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  bundle_type wr_data,
   input  logic       rd_en,
   output bundle_type rd_data,
   output logic       full,
   output logic       empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/bed_back.sv
module bed_back
   import bed_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  bundle_type         head,
   input  logic               queue_empty,
   output logic               queue_pop,
   input  logic               pop,
   output logic               empty,
   output logic [PIX_W-1:0]   rsp_out_value,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic [COORD_W-1:0] rsp_out_col,
   output logic               rsp_last,
   output logic               rsp_frame_done
);

   logic [SLOTS-1:0]   work_mask_ff, work_mask_in;
   logic [SLOTS-1:0]   work_bits_ff;
   logic [COORD_W-1:0] work_row_ff;
   logic [COORD_W-1:0] work_col_ff;
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_value_ff;
   logic [COORD_W-1:0] out_row_ff;
   logic [COORD_W-1:0] out_col_ff;
   logic               out_last_ff;
   logic               out_done_ff;

   logic               out_free;
   logic               emit;
   logic [1:0]         idx;
   logic [SLOTS-1:0]   low;
   logic [SLOTS-1:0]   mask_after;
   logic               load;
   logic [COORD_W-1:0] sel_row, sel_col;

   assign out_free   = !out_valid_ff || pop;
   assign emit       = out_free && (work_mask_ff != '0);
   assign idx        = low_slot(work_mask_ff);
   assign low        = SLOTS'(1) << idx;
   assign mask_after = emit ? (work_mask_ff & ~low) : work_mask_ff;
   assign load       = (mask_after == '0) && !queue_empty;
   assign queue_pop  = load;

   // Position of the selected slot
   always_comb begin
      unique case (idx)
         SLOT_UP_LEFT: begin
            sel_row = work_row_ff - COORD_W'(1);
            sel_col = work_col_ff - COORD_W'(1);
         end
         SLOT_UP: begin
            sel_row = work_row_ff - COORD_W'(1);
            sel_col = work_col_ff;
         end
         SLOT_LEFT: begin
            sel_row = work_row_ff;
            sel_col = work_col_ff - COORD_W'(1);
         end
         default: begin
            sel_row = work_row_ff;
            sel_col = work_col_ff;
         end
      endcase
   end

   // Drop emitted slots, take the next request from the queue
   always_comb begin
      work_mask_in = load ? head.mask : mask_after;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_mask_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         work_mask_ff <= work_mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_bits_ff <= head.bits;
         work_row_ff  <= head.row;
         work_col_ff  <= head.col;
      end
      if (emit) begin
         out_value_ff <= work_bits_ff[idx] ? FG_VALUE : BG_VALUE;
         out_row_ff   <= sel_row;
         out_col_ff   <= sel_col;
         out_last_ff  <= (mask_after == '0);
         out_done_ff  <= (idx == SLOT_CORNER);
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_frame_done = out_done_ff;

endmodule

// File: rtl/binary_erode_dilate_2x2_core.sv
// 2x2 binary erosion/dilation of a raster-order pixel stream. A pixel counts as
// foreground only when it equals 255; result (r,c) is the AND (mode 0) or OR
// (mode 1) of the pixels at (r,c), (r,c+1), (r+1,c), (r+1,c+1), with pixels
// outside the frame as background, and reads 255 or 0. One pixel is taken per
// clock while the four-entry request queue has room; the result side drains one
// result per clock while results are popped. Pixels in the first row or first
// column complete no window of their own, other pixels complete one, a pixel
// ending a row completes two, a pixel in the last row two and the final pixel
// of the frame up to four. The silent first column absorbs the extra row-end
// result, so the stream keeps one pixel per cycle through the frame except along
// the last row, where the queue fills and pixels wait for room. A held result
// stalls only the result side until the queue fills. A result passes through the
// request queue, the working register and the output register to the ports. The
// previous row sits in a MAX_WIDTH x 1 line store whose next-column entry is read
// ahead; it is not cleared after reset and needs no clearing pass. Write the
// size and mode registers only between frames while the block is idle.
module binary_erode_dilate_2x2_core
   import bed_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   input  logic                  push,
   output logic                  full,
   input  logic [PIX_W-1:0]      req_pixel,
   output logic                  empty,
   input  logic                  pop,
   output logic [PIX_W-1:0]      rsp_out_value,
   output logic [COORD_W-1:0]    rsp_out_row,
   output logic [COORD_W-1:0]    rsp_out_col,
   output logic                  rsp_last,
   output logic                  rsp_frame_done
);

   localparam int QUEUE_DEPTH = 4;

   cfg_type    cfg_ff;
   logic       bundle_valid;
   bundle_type bundle;
   bundle_type head;
   logic       queue_full;
   logic       queue_empty;
   logic       queue_pop;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= RESET_WIDTH;
         cfg_ff.image_height <= RESET_HEIGHT;
         cfg_ff.mode         <= MODE_ERODE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            CSR_MODE:         cfg_ff.mode         <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   bed_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .push         (push),
      .req_pixel    (req_pixel),
      .queue_full   (queue_full),
      .bundle_valid (bundle_valid),
      .bundle       (bundle)
   );

   bed_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_valid),
      .wr_data (bundle),
      .rd_en   (queue_pop),
      .rd_data (head),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   bed_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .queue_empty    (queue_empty),
      .queue_pop      (queue_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_last       (rsp_last),
      .rsp_frame_done (rsp_frame_done)
   );

   assign full = queue_full;

endmodule
